### design/ihex_pkg.sv
`default_nettype none
// ============================================================================
// ihex_pkg
// Shared types, codes and helpers of the Intel HEX record decoder.
// ============================================================================
package ihex_pkg;

    // input request kinds
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // characters of interest
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // record types
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_SEG = 8'h02;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    // line geometry
    localparam logic [9:0] POS_MAX       = 10'd1023;
    localparam logic [9:0] MIN_LINE      = 10'd11;
    localparam logic [9:0] MIN_TRIMMED   = 10'd9;
    localparam logic [9:0] POS_COUNT     = 10'd2;
    localparam logic [9:0] POS_ADDR_HI   = 10'd4;
    localparam logic [9:0] POS_ADDR_LO   = 10'd6;
    localparam logic [9:0] POS_TYPE      = 10'd8;
    localparam logic [9:0] POS_DATA      = 10'd10;

    // error codes; codes malformed to checksum field double as line fault codes
    localparam logic [2:0] ERR_NO_EOF    = 3'd0;
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MALFORMED = 3'd1;
    localparam logic [2:0] ERR_LENGTH    = 3'd2;
    localparam logic [2:0] ERR_DATA      = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
    localparam logic [2:0] ERR_MISMATCH  = 3'd5;
    localparam logic [2:0] ERR_SHORT_EXT = 3'd6;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_EOF    = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RUN_ACTIVE  = 2'd0,
        RUN_DONE    = 2'd1,
        RUN_STOPPED = 2'd2
    } run_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [2:0]  err;
        logic        last;
    } result_t;

    // results caused by one request
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            v = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            v = {1'b1, 4'(c - 8'h37)};
        return v;
    endfunction

endpackage
`default_nettype wire

### design/ihex_parser.sv
`default_nettype none
// ============================================================================
// ihex_parser
// Line state of the decoder and the single-pass step logic for one request.
// ============================================================================
module ihex_parser
    import ihex_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic       fire,
    input  wire logic       req_type,
    input  wire logic [7:0] char_code,
    output step_t           step
);

    logic [31:0] upper_base_reg, upper_base_next;
    logic [9:0]  line_position_reg, line_position_next;
    logic [7:0]  declared_count_reg, declared_count_next;
    logic [15:0] record_offset_reg, record_offset_next;
    logic [7:0]  record_kind_reg, record_kind_next;
    logic [7:0]  byte_sum_reg, byte_sum_next;
    logic [3:0]  pending_nibble_reg, pending_nibble_next;
    logic [15:0] extension_bytes_reg, extension_bytes_next;
    logic [2:0]  line_fault_reg, line_fault_next;
    logic        trailing_space_reg, trailing_space_next;
    run_t        run_status_reg, run_status_next;

    // fault after the length check of a line of len characters
    function automatic logic [2:0] length_check(input logic [2:0] fault,
                                                input logic [9:0] len,
                                                input logic [7:0] count);
        logic [2:0] f;
        f = fault;
        if (fault != ERR_MALFORMED) begin
            if (len < MIN_TRIMMED)
                f = ERR_MALFORMED;
            else if (len != (MIN_LINE + {1'b0, count, 1'b0}))
                f = ERR_LENGTH;
        end
        return f;
    endfunction

    // step logic
    always_comb
    begin
        logic [9:0]  pos;
        logic        is_ws;
        logic        finish_now;
        logic        still_running;
        logic [4:0]  nib;
        logic [7:0]  b;
        logic [8:0]  idx;
        logic [2:0]  fault_eff;
        logic [7:0]  d0;
        logic [7:0]  d1;
        result_t     fin;
        result_t     tail;

        pos           = line_position_reg;
        is_ws         = (char_code == CHAR_SPACE) || (char_code == CHAR_CR) ||
                        (char_code == CHAR_TAB);
        nib           = hex_nibble(char_code);
        b             = {pending_nibble_reg, nib[3:0]};
        idx           = 9'((pos - POS_DATA) >> 1);
        d0            = extension_bytes_reg[15:8];
        d1            = extension_bytes_reg[7:0];
        fault_eff     = trailing_space_reg ? line_fault_reg :
                        length_check(line_fault_reg, pos, declared_count_reg);
        finish_now    = 1'b0;
        still_running = 1'b1;
        fin           = '0;
        tail          = '0;

        upper_base_next      = upper_base_reg;
        line_position_next   = line_position_reg;
        declared_count_next  = declared_count_reg;
        record_offset_next   = record_offset_reg;
        record_kind_next     = record_kind_reg;
        byte_sum_next        = byte_sum_reg;
        pending_nibble_next  = pending_nibble_reg;
        extension_bytes_next = extension_bytes_reg;
        line_fault_next      = line_fault_reg;
        trailing_space_next  = trailing_space_reg;
        run_status_next      = run_status_reg;

        step = '0;

        if (item_valid && run_status_reg == RUN_ACTIVE) begin
            if (req_type == REQ_END || char_code == CHAR_LF) begin
                finish_now = (req_type == REQ_CHAR) || (pos != 10'd0);

                // line end verdict
                fin.kind = KIND_ERROR;
                if (pos < MIN_LINE) begin
                    fin.err = ERR_NO_EOF;
                    run_status_next = RUN_STOPPED;
                end else if (fault_eff != ERR_NONE) begin
                    fin.err = fault_eff;
                    run_status_next = RUN_STOPPED;
                end else if (byte_sum_reg != 8'd0) begin
                    fin.err = ERR_MISMATCH;
                    run_status_next = RUN_STOPPED;
                end else if ((record_kind_reg == REC_EXT_SEG ||
                              record_kind_reg == REC_EXT_LIN) &&
                             declared_count_reg < 8'd2) begin
                    fin.err = ERR_SHORT_EXT;
                    run_status_next = RUN_STOPPED;
                end else if (record_kind_reg == REC_EOF) begin
                    fin.kind = KIND_EOF;
                    run_status_next = RUN_DONE;
                end else begin
                    fin.kind = KIND_ACCEPT;
                    if (record_kind_reg == REC_EXT_SEG)
                        upper_base_next = {12'd0, d0, d1, 4'd0};
                    else if (record_kind_reg == REC_EXT_LIN)
                        upper_base_next = {d0, d1, 16'd0};
                end

                if (finish_now) begin
                    still_running        = (fin.kind == KIND_ACCEPT);
                    line_position_next   = '0;
                    declared_count_next  = '0;
                    record_offset_next   = '0;
                    record_kind_next     = '0;
                    byte_sum_next        = '0;
                    pending_nibble_next  = '0;
                    extension_bytes_next = '0;
                    line_fault_next      = ERR_NONE;
                    trailing_space_next  = 1'b0;
                end else begin
                    upper_base_next = upper_base_reg;
                    run_status_next = run_status_reg;
                end

                // end of stream with the load still open
                tail.kind = KIND_ERROR;
                tail.err  = ERR_NO_EOF;
                tail.last = 1'b1;
                if (req_type == REQ_END && still_running) begin
                    run_status_next = RUN_STOPPED;
                    if (finish_now) begin
                        step.count = 2'd2;
                        step.r0    = fin;
                        step.r1    = tail;
                    end else begin
                        step.count = 2'd1;
                        step.r0    = tail;
                    end
                end else begin
                    fin.last   = 1'b1;
                    step.count = 2'd1;
                    step.r0    = fin;
                end
            end else begin
                // one text character
                if (pos < POS_MAX)
                    line_position_next = pos + 10'd1;
                if (is_ws) begin
                    if (!trailing_space_reg) begin
                        trailing_space_next = 1'b1;
                        line_fault_next = length_check(line_fault_reg, pos,
                                                       declared_count_reg);
                    end
                end else if (trailing_space_reg) begin
                    line_fault_next = ERR_MALFORMED;
                end else if (pos == 10'd0) begin
                    if (char_code != CHAR_COLON && line_fault_reg == ERR_NONE)
                        line_fault_next = ERR_MALFORMED;
                end else if (!nib[4]) begin
                    if (line_fault_reg == ERR_NONE) begin
                        if (pos <= POS_TYPE)
                            line_fault_next = ERR_MALFORMED;
                        else if (pos < (10'd9 + {1'b0, declared_count_reg, 1'b0}))
                            line_fault_next = ERR_DATA;
                        else if (pos <= (POS_DATA + {1'b0, declared_count_reg, 1'b0}))
                            line_fault_next = ERR_CHECKSUM;
                    end
                end else if (pos[0]) begin
                    pending_nibble_next = nib[3:0];
                end else begin
                    byte_sum_next = byte_sum_reg + b;
                    if (pos == POS_COUNT)
                        declared_count_next = b;
                    else if (pos == POS_ADDR_HI)
                        record_offset_next = {b, record_offset_reg[7:0]};
                    else if (pos == POS_ADDR_LO)
                        record_offset_next = {record_offset_reg[15:8], b};
                    else if (pos == POS_TYPE)
                        record_kind_next = b;
                    else if (pos >= POS_DATA && idx < {1'b0, declared_count_reg}) begin
                        if (idx == 9'd0)
                            extension_bytes_next = {b, extension_bytes_reg[7:0]};
                        else if (idx == 9'd1)
                            extension_bytes_next = {extension_bytes_reg[15:8], b};
                        if (record_kind_reg == REC_DATA && line_fault_reg == ERR_NONE)
                        begin
                            step.count   = 2'd1;
                            step.r0.kind = KIND_DATA;
                            step.r0.addr = upper_base_reg + {16'd0, record_offset_reg} +
                                           {23'd0, idx};
                            step.r0.data = b;
                            step.r0.last = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // state registers, updated when the request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upper_base_reg      <= '0;
            line_position_reg   <= '0;
            declared_count_reg  <= '0;
            record_offset_reg   <= '0;
            record_kind_reg     <= '0;
            byte_sum_reg        <= '0;
            pending_nibble_reg  <= '0;
            extension_bytes_reg <= '0;
            line_fault_reg      <= ERR_NONE;
            trailing_space_reg  <= 1'b0;
            run_status_reg      <= RUN_ACTIVE;
        end else if (fire) begin
            upper_base_reg      <= upper_base_next;
            line_position_reg   <= line_position_next;
            declared_count_reg  <= declared_count_next;
            record_offset_reg   <= record_offset_next;
            record_kind_reg     <= record_kind_next;
            byte_sum_reg        <= byte_sum_next;
            pending_nibble_reg  <= pending_nibble_next;
            extension_bytes_reg <= extension_bytes_next;
            line_fault_reg      <= line_fault_next;
            trailing_space_reg  <= trailing_space_next;
            run_status_reg      <= run_status_next;
        end
    end

    // two results only as an accepted line followed by the missing-eof error
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && step.count == 2'd2) |->
        (step.r0.kind == KIND_ACCEPT && step.r1.kind == KIND_ERROR))
        else $error("two results not accepted line plus error");

    // once finished the block never resumes
    a_sticky_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (run_status_reg != RUN_ACTIVE) |=> (run_status_reg == $past(run_status_reg)))
        else $error("run status left its final value");

    // an error result always stops the block
    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && step.count != 2'd0 && step.r0.kind == KIND_ERROR) |=>
        (run_status_reg == RUN_STOPPED))
        else $error("error result without stop");

endmodule
`default_nettype wire

### design/ihex_out_queue.sv
`default_nettype none
// ============================================================================
// ihex_out_queue
// Two-entry result register; takes up to two results per cycle.
// ============================================================================
module ihex_out_queue
    import ihex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  push_count,
    input  result_t          push0,
    input  result_t          push1,
    output logic [1:0]       free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // write_address, write_data, error_code, zero pad
    output logic [1:0]       m_tuser,  // result_kind
    output logic             m_tlast   // last_result
);

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop  = (count_reg != 2'd0) && m_tready;
    assign free = 2'(3'd2 - {1'b0, count_reg} + {2'd0, pop});

    // shift out on pop, then append new results behind the survivors
    always_comb
    begin
        logic [1:0] kept;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        kept       = count_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            kept       = count_reg - 2'd1;
        end
        case (kept)
            2'd0:
            begin
                if (push_count != 2'd0)
                    slot0_next = push0;
                if (push_count == 2'd2)
                    slot1_next = push1;
            end
            2'd1:
            begin
                if (push_count != 2'd0)
                    slot1_next = push0;
            end
            default:
            begin
                slot1_next = slot1_reg;
            end
        endcase
        count_next = kept + push_count;
    end

    // slot registers carry payload only
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {5'd0, slot0_reg.err, slot0_reg.data, slot0_reg.addr};
    assign m_tuser  = slot0_reg.kind;
    assign m_tlast  = slot0_reg.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> (push_count <= free))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_DATA) |-> (m_tdata[39:0] == 40'd0))
        else $error("non-data result carries address or data");

endmodule
`default_nettype wire

### design/intel_hex_record_decoder.sv
`default_nettype none
// ============================================================================
// intel_hex_record_decoder
// Parses Intel HEX text a character at a time into provisional byte writes
// and per-line verdicts.
// ============================================================================
// Usage:
//   s_* carries requests: s_tdata holds the character, s_tuser set marks end
//   of the input stream. m_* carries results: the kind in m_tuser, address,
//   data and error code in m_tdata, m_tlast on the final result of a request.
//   Data bytes of a type 0 line appear as provisional writes; the line-end
//   result (accepted or error) commits or discards them.
//   Requests pass input and result registers in turn. One request is taken
//   every cycle; a request is held in the input register until the two-entry
//   result register has room for all of its results (at most two, only for
//   end of stream after an unterminated line).
//   After an end-of-file record or the first error the block answers no
//   further requests but keeps taking them.
//   Reset clears the line state, the upper address base and the result
//   register. When the receiver stalls, results wait in the result register
//   and one more request is held before s_tready drops.
// ============================================================================
module intel_hex_record_decoder
    import ihex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // char_code
    input  wire logic        s_tuser,  // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // write_address, write_data, error_code, zero pad
    output logic [1:0]       m_tuser,  // result_kind
    output logic             m_tlast   // last_result
);

    logic       in_valid_reg, in_valid_next;
    logic       req_type_reg;
    logic [7:0] char_code_reg;
    logic       fire;
    logic [1:0] free;
    step_t      step;

    // request register
    assign fire          = in_valid_reg && (step.count <= free);
    assign s_tready      = !in_valid_reg || fire;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            req_type_reg  <= s_tuser;
            char_code_reg <= s_tdata;
        end
    end

    // parse step
    ihex_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .fire       (fire),
        .req_type   (req_type_reg),
        .char_code  (char_code_reg),
        .step       (step)
    );

    // result register
    ihex_out_queue u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (fire ? step.count : 2'd0),
        .push0      (step.r0),
        .push1      (step.r1),
        .free       (free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

### sim/tb_intel_hex_record_decoder.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_intel_hex_record_decoder
// Self-checking bench for the Intel HEX text decoder. Hex text goes in one
// character per request with random gaps and random result back-pressure.
// A built-in line parser predicts every provisional write and line verdict.
// Directed records come first, then a long run of random well-formed records.
// A randomly chosen closing case ends the load, and the bench then checks
// that later requests give no results.
// ============================================================================
module tb_intel_hex_record_decoder;
    import ihex_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 26;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_BYTES   = 64;

    // ways the load is brought to its end
    typedef enum int {
        CLOSE_STREAM,
        CLOSE_EOF_RECORD,
        CLOSE_OPEN_LINE,
        CLOSE_BAD_START,
        CLOSE_BAD_HEADER,
        CLOSE_BAD_DATA,
        CLOSE_BAD_CHECKSUM,
        CLOSE_BAD_TAIL,
        CLOSE_WRONG_LENGTH,
        CLOSE_WRONG_SUM,
        CLOSE_SHORT_EXT,
        CLOSE_SHORT_LINE,
        CLOSE_INNER_BLANK,
        CLOSE_TRIMMED_SHORT,
        CLOSE_OVERLONG
    } closing_case_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;  // char_code
    logic        s_tuser = 1'b0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // write_address, write_data, error_code, zero pad
    logic [1:0]  m_tuser;          // result_kind
    logic        m_tlast;

    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    int fail_count = 0;
    int requests_taken = 0;
    int results_seen = 0;
    int writes_seen = 0;
    int records_seen = 0;
    int stall_cycles = 0;
    closing_case_t closing_case = CLOSE_STREAM;

    // parser state of the prediction
    logic [31:0] seg_base;
    logic [9:0]  col;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic [7:0]  csum;
    logic [3:0]  hi_nib;
    logic [15:0] ext_word;
    logic [2:0]  fault;
    logic        trail_ws;
    run_t        run_state;

    result_t expected_results[$];
    result_t step_results[$];

    // stimulus buffers
    logic [7:0] line_buf[$];
    logic [7:0] rec_bytes[$];

    intel_hex_record_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #(HALF_PERIOD) clk = ~clk;
    end

    // random back-pressure on results
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // line parser prediction
    // ------------------------------------------------------------------------
    function automatic int digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void clear_record();
        col      = '0;
        rec_len  = '0;
        rec_addr = '0;
        rec_type = '0;
        csum     = '0;
        hi_nib   = '0;
        ext_word = '0;
        fault    = ERR_NONE;
        trail_ws = 1'b0;
    endfunction

    function automatic void reset_parser();
        seg_base  = '0;
        run_state = RUN_ACTIVE;
        clear_record();
    endfunction

    function automatic void add_result(kind_t kind, logic [31:0] addr, logic [7:0] data,
                                       logic [2:0] err);
        result_t r;
        r.kind = kind;
        r.addr = addr;
        r.data = data;
        r.err  = err;
        r.last = 1'b0;
        step_results = {step_results, r};
    endfunction

    function automatic void stop_with(logic [2:0] err);
        add_result(KIND_ERROR, '0, '0, err);
        run_state = RUN_STOPPED;
    endfunction

    // trimmed length against the declared count; malformed stays malformed
    function automatic void check_trimmed_length(logic [9:0] len);
        if (fault == ERR_MALFORMED)
            return;
        if (len < MIN_TRIMMED)
            fault = ERR_MALFORMED;
        else if (int'(len) != int'(MIN_LINE) + 2 * int'(rec_len))
            fault = ERR_LENGTH;
    endfunction

    // line feed: verdict of the current line
    function automatic void close_line();
        logic [7:0] hi_byte;
        logic [7:0] lo_byte;
        hi_byte = ext_word[15:8];
        lo_byte = ext_word[7:0];
        if (col < MIN_LINE)
            stop_with(ERR_NO_EOF);
        else
        begin
            if (!trail_ws)
                check_trimmed_length(col);
            if (fault != ERR_NONE)
                stop_with(fault);
            else if (csum != 8'h00)
                stop_with(ERR_MISMATCH);
            else if ((rec_type == REC_EXT_SEG || rec_type == REC_EXT_LIN) && rec_len < 8'd2)
                stop_with(ERR_SHORT_EXT);
            else if (rec_type == REC_EOF)
            begin
                add_result(KIND_EOF, '0, '0, ERR_NONE);
                run_state = RUN_DONE;
            end
            else
            begin
                if (rec_type == REC_EXT_SEG)
                    seg_base = {12'd0, hi_byte, lo_byte, 4'd0};
                else if (rec_type == REC_EXT_LIN)
                    seg_base = {hi_byte, lo_byte, 16'd0};
                add_result(KIND_ACCEPT, '0, '0, ERR_NONE);
            end
        end
        clear_record();
    endfunction

    // any character other than line feed
    function automatic void take_char(logic [7:0] c);
        logic [9:0] pos;
        logic [7:0] b;
        int         nib;
        int         idx;
        pos = col;
        if (col < POS_MAX)
            col = col + 10'd1;
        if (c == CHAR_SPACE || c == CHAR_CR || c == CHAR_TAB)
        begin
            if (!trail_ws)
            begin
                trail_ws = 1'b1;
                check_trimmed_length(pos);
            end
            return;
        end
        // text after trailing blanks
        if (trail_ws)
        begin
            fault = ERR_MALFORMED;
            return;
        end
        if (pos == 0)
        begin
            if (c != CHAR_COLON && fault == ERR_NONE)
                fault = ERR_MALFORMED;
            return;
        end
        nib = digit_value(c);
        if (nib < 0)
        begin
            if (fault == ERR_NONE)
            begin
                if (pos <= POS_TYPE)
                    fault = ERR_MALFORMED;
                else if (int'(pos) < int'(MIN_TRIMMED) + 2 * int'(rec_len))
                    fault = ERR_DATA;
                else if (int'(pos) <= int'(POS_DATA) + 2 * int'(rec_len))
                    fault = ERR_CHECKSUM;
            end
            return;
        end
        if (pos[0])
        begin
            hi_nib = nib[3:0];
            return;
        end
        b    = {hi_nib, nib[3:0]};
        csum = csum + b;
        if (pos == POS_COUNT)
            rec_len = b;
        else if (pos == POS_ADDR_HI)
            rec_addr[15:8] = b;
        else if (pos == POS_ADDR_LO)
            rec_addr[7:0] = b;
        else if (pos == POS_TYPE)
            rec_type = b;
        else if (pos >= POS_DATA)
        begin
            idx = int'(pos - POS_DATA) >> 1;
            if (idx < int'(rec_len))
            begin
                if (idx == 0)
                    ext_word[15:8] = b;
                else if (idx == 1)
                    ext_word[7:0] = b;
                if (rec_type == REC_DATA && fault == ERR_NONE)
                    add_result(KIND_DATA, seg_base + 32'(rec_addr) + 32'(idx), b, ERR_NONE);
            end
        end
    endfunction

    // expected results of one accepted request
    function automatic void decode_request(logic req, logic [7:0] c);
        step_results.delete();
        if (run_state != RUN_ACTIVE)
            return;
        if (req == REQ_END)
        begin
            if (col != 0)
                close_line();
            if (run_state == RUN_ACTIVE)
                stop_with(ERR_NO_EOF);
        end
        else if (c == CHAR_LF)
            close_line();
        else
            take_char(c);
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
        expected_results = {expected_results, step_results};
    endfunction

    // ------------------------------------------------------------------------
    // request tracking and result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_request(s_tuser, s_tdata);
                requests_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d tdata 0x%0h", m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, m_tuser);
                    check_field("write_address", want.addr, m_tdata[31:0]);
                    check_field("write_data", want.data, m_tdata[39:32]);
                    check_field("error_code", want.err, m_tdata[42:40]);
                    check_field("tdata pad", 32'd0, m_tdata[47:43]);
                    check_field("last_result", want.last, m_tlast);
                    if (want.kind == KIND_DATA)
                        writes_seen++;
                    else if (want.kind == KIND_ACCEPT)
                        records_seen++;
                end
            end
        end
    end

    // watchdog on cycles with no request and no result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
                $display("** intel_hex_record_decoder: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // append one character to the line text
    function automatic void put_char(logic [7:0] c);
        line_buf = {line_buf, c};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10)
            return "0" + n;
        return (lower ? "a" : "A") + (n - 4'd10);
    endfunction

    function automatic logic [7:0] blank_char(int k);
        case (k % 3)
            0:       return CHAR_CR;
            1:       return CHAR_SPACE;
            default: return CHAR_TAB;
        endcase
    endfunction

    // any character that is neither hex, blank, colon nor line feed
    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (digit_value(c) >= 0 || c == CHAR_LF || c == CHAR_COLON || c == CHAR_SPACE ||
               c == CHAR_CR || c == CHAR_TAB);
        return c;
    endfunction

    // letter case: 0 upper, 1 lower, 2 mixed per byte
    function automatic void append_byte(logic [7:0] b, int letter_case);
        bit lower;
        lower = (letter_case == 2) ? 1'($urandom_range(1)) : (letter_case == 1);
        put_char(hex_char(b[7:4], lower));
        put_char(hex_char(b[3:0], lower));
    endfunction

    function automatic void fill_bytes(int n);
        rec_bytes.delete();
        repeat (n) rec_bytes = {rec_bytes, 8'($urandom)};
    endfunction

    // well-formed record text from rec_bytes, no line end
    function automatic void build_record(logic [7:0] rtype, logic [15:0] offset,
                                         int letter_case);
        logic [7:0] sum;
        logic [7:0] len;
        len = 8'(rec_bytes.size());
        sum = len + offset[15:8] + offset[7:0] + rtype;
        line_buf.delete();
        put_char(CHAR_COLON);
        append_byte(len, letter_case);
        append_byte(offset[15:8], letter_case);
        append_byte(offset[7:0], letter_case);
        append_byte(rtype, letter_case);
        foreach (rec_bytes[i])
        begin
            append_byte(rec_bytes[i], letter_case);
            sum = sum + rec_bytes[i];
        end
        append_byte(~sum + 8'd1, letter_case);
    endfunction

    // one request with a random gap in front
    task automatic send_item(logic req, logic [7:0] c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_buffer();
        foreach (line_buf[i])
            send_item(REQ_CHAR, line_buf[i]);
    endtask

    task automatic send_record(logic [7:0] rtype, logic [15:0] offset, int letter_case,
                               int blanks);
        build_record(rtype, offset, letter_case);
        for (int i = 0; i < blanks; i++)
            put_char(blank_char(i));
        put_char(CHAR_LF);
        send_buffer();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // empty data line, byte extremes at the top of the offset range, mixed case
    task automatic test_data_records();
        rec_bytes.delete();
        send_record(REC_DATA, 16'h0000, 0, 0);
        rec_bytes = '{8'h00, 8'hFF};
        send_record(REC_DATA, 16'hFFFF, 1, 0);
        rec_bytes = '{8'hA5};
        send_record(REC_DATA, 16'h1234, 2, 0);
    endtask

    // linear and segment bases, wrap of the 32-bit write address
    task automatic test_extended_address();
        rec_bytes = '{8'hFF, 8'hFF};
        send_record(REC_EXT_LIN, 16'h0000, 0, 0);
        rec_bytes = '{8'h5A, 8'hC3};
        send_record(REC_DATA, 16'hFFFF, 1, 0);
        rec_bytes = '{8'hFF, 8'hFF, 8'h00};
        send_record(REC_EXT_SEG, 16'h0000, 2, 0);
        rec_bytes = '{8'h3C};
        send_record(REC_DATA, 16'h0010, 0, 0);
        rec_bytes = '{8'h00, 8'h00};
        send_record(REC_EXT_LIN, 16'h0000, 1, 0);
    endtask

    // unknown record types and trailing blanks
    task automatic test_other_types_and_blanks();
        fill_bytes(4);
        send_record(8'h03, 16'($urandom), 0, 3);
        rec_bytes.delete();
        send_record(8'h05, 16'h0000, 1, 3);
        fill_bytes(2);
        send_record(REC_DATA, 16'h8000, 2, 1);
    endtask

    // random well-formed records, one long record sent with no idling
    task automatic test_random_records();
        int         sent_chars;
        int         big_at;
        int         pick;
        int         blanks;
        bit         big_done;
        logic [7:0] rtype;
        sent_chars = 0;
        big_done   = 1'b0;
        big_at     = $urandom_range(RANDOM_ITEMS - 150);
        while (sent_chars < RANDOM_ITEMS)
        begin
            if (!big_done && sent_chars >= big_at)
            begin
                // long record with no idling on either side
                fill_bytes(LONG_BYTES);
                send_idle_pct = 0;
                recv_idle_pct = 0;
                send_record(REC_DATA, 16'($urandom), $urandom_range(2), 0);
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
                big_done = 1'b1;
                sent_chars += line_buf.size();
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    fill_bytes($urandom_range(16));
                    rtype = REC_DATA;
                end
                else if (pick < 80)
                begin
                    fill_bytes($urandom_range(2, 3));
                    rtype = REC_EXT_LIN;
                end
                else if (pick < 90)
                begin
                    fill_bytes($urandom_range(2, 3));
                    rtype = REC_EXT_SEG;
                end
                else
                begin
                    fill_bytes($urandom_range(4));
                    do
                        rtype = 8'($urandom_range(255));
                    while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_EXT_SEG ||
                           rtype == REC_EXT_LIN);
                end
                blanks = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
                send_record(rtype, 16'($urandom), $urandom_range(2), blanks);
                sent_chars += line_buf.size();
            end
        end
    endtask

    // one random way of ending the load, then end of stream
    task automatic test_closing();
        int n;
        int k;
        closing_case = closing_case_t'($urandom_range(CLOSE_OVERLONG));
        n = $urandom_range(1, 6);
        fill_bytes(n);
        build_record(REC_DATA, 16'($urandom), $urandom_range(2));
        case (closing_case)
            CLOSE_STREAM:
                line_buf.delete();
            CLOSE_EOF_RECORD:
            begin
                rec_bytes.delete();
                build_record(REC_EOF, 16'h0000, 0);
            end
            CLOSE_OPEN_LINE:
                if ($urandom_range(1) == 0)
                begin
                    rec_bytes.delete();
                    build_record(REC_EOF, 16'h0000, 0);
                end
            CLOSE_BAD_START:
                line_buf[0] = bad_char();
            CLOSE_BAD_HEADER:
                line_buf[$urandom_range(1, 8)] = bad_char();
            CLOSE_BAD_DATA:
                line_buf[$urandom_range(9, 8 + 2 * n)] = bad_char();
            CLOSE_BAD_CHECKSUM:
                line_buf[9 + 2 * n + $urandom_range(1)] = bad_char();
            CLOSE_BAD_TAIL:
                put_char(bad_char());
            CLOSE_WRONG_LENGTH:
                if ($urandom_range(1) == 0)
                begin
                    put_char(hex_char(4'($urandom), 1'b0));
                    put_char(hex_char(4'($urandom), 1'b0));
                end
                else
                begin
                    void'(line_buf.pop_back());
                    void'(line_buf.pop_back());
                end
            CLOSE_WRONG_SUM:
            begin
                k = line_buf.size() - 1;
                line_buf[k] = hex_char(4'(digit_value(line_buf[k])) ^ 4'($urandom_range(1, 15)),
                                       1'b0);
            end
            CLOSE_SHORT_EXT:
            begin
                fill_bytes($urandom_range(1));
                build_record(($urandom_range(1) == 0) ? REC_EXT_SEG : REC_EXT_LIN,
                             16'($urandom), $urandom_range(2));
            end
            CLOSE_SHORT_LINE:
            begin
                k = $urandom_range(10);
                while (line_buf.size() > k)
                    void'(line_buf.pop_back());
            end
            CLOSE_INNER_BLANK:
                line_buf.insert($urandom_range(1, line_buf.size() - 1),
                                blank_char($urandom_range(2)));
            CLOSE_TRIMMED_SHORT:
            begin
                k = $urandom_range(1, 8);
                while (line_buf.size() > k)
                    void'(line_buf.pop_back());
                while (line_buf.size() < 11)
                    put_char(blank_char(line_buf.size()));
            end
            default:
            begin
                // line of random hex digits whose length seldom fits its declared count
                line_buf.delete();
                put_char(CHAR_COLON);
                repeat (60) put_char(hex_char(4'($urandom), 1'($urandom)));
            end
        endcase
        if (closing_case != CLOSE_STREAM && closing_case != CLOSE_OPEN_LINE)
            put_char(CHAR_LF);
        send_buffer();
        send_item(REQ_END, 8'($urandom));
    endtask

    // requests after the load has ended give nothing back
    task automatic test_quiet_after_end();
        send_item(REQ_CHAR, 8'h00);
        send_item(REQ_CHAR, 8'hFF);
        send_item(REQ_CHAR, CHAR_LF);
        repeat (20) send_item(1'($urandom_range(3) == 0), 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_data_records();
        test_extended_address();
        test_other_types_and_blanks();
        test_random_records();
        test_closing();
        test_quiet_after_end();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests, %0d results: %0d byte writes, %0d records accepted",
                 requests_taken, results_seen, writes_seen, records_seen);
        $display("load ended by case %s, followed by ignored requests", closing_case.name());
        if (fail_count == 0)
            $display("** intel_hex_record_decoder: PASSED **");
        else
            $display("** intel_hex_record_decoder: FAILED **");
        $finish;
    end

endmodule

### filelist.f
design/ihex_pkg.sv
design/ihex_parser.sv
design/ihex_out_queue.sv
design/intel_hex_record_decoder.sv
sim/tb_intel_hex_record_decoder.sv
